// ===== rtl/las_pkg.sv =====
// shared constants and defaults for the life automaton step block
`default_nettype none
package las_pkg;

   localparam int GRID_WIDTH_DEF  = 16;
   localparam int GRID_HEIGHT_DEF = 16;

   localparam int CMD_W       = 2;
   localparam int ROW_INDEX_W = 4;
   localparam int ROW_CELLS_W = 16;

   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STEP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

   localparam logic CELL_ALIVE = 1'b1;
   localparam logic CELL_DEAD  = 1'b0;

   localparam logic [3:0] NB_KEEP  = 4'd2;
   localparam logic [3:0] NB_BIRTH = 4'd3;

endpackage
`default_nettype wire

// ===== rtl/las_req_if.sv =====
// command channel: command, row index and row cells
`default_nettype none
interface las_req_if;
   import las_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CMD_W-1:0]       command;
   logic [ROW_INDEX_W-1:0] row_index;
   logic [ROW_CELLS_W-1:0] row_cells;

   modport source (output valid, output command, output row_index, output row_cells,
                   input ready);
   modport sink   (input valid, input command, input row_index, input row_cells,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/las_rsp_if.sv =====
// result channel: row data and completed command code
`default_nettype none
interface las_rsp_if;
   import las_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ROW_CELLS_W-1:0] row_data;
   logic [CMD_W-1:0]       done_kind;

   modport source (output valid, output row_data, output done_kind, input ready);
   modport sink   (input valid, input row_data, input done_kind, output ready);
endinterface
`default_nettype wire

// ===== rtl/las_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none
module las_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/las_row_unit.sv =====
// next generation of one row from the rows above, itself and below
`default_nettype none
module las_row_unit #(
   parameter int GRID_WIDTH = las_pkg::GRID_WIDTH_DEF
) (
   input  wire logic [GRID_WIDTH-1:0] above,
   input  wire logic [GRID_WIDTH-1:0] self_row,
   input  wire logic [GRID_WIDTH-1:0] below,
   output logic      [GRID_WIDTH-1:0] next_row
);
   import las_pkg::*;

   for (genvar x = 0; x < GRID_WIDTH; x++) begin : g_col
      localparam int XL = (x + GRID_WIDTH - 1) % GRID_WIDTH;
      localparam int XR = (x + 1) % GRID_WIDTH;
      logic [3:0] cnt;

      assign cnt = 4'(above[XL]) + 4'(above[x]) + 4'(above[XR])
                 + 4'(self_row[XL]) + 4'(self_row[XR])
                 + 4'(below[XL]) + 4'(below[x]) + 4'(below[XR]);
      assign next_row[x] = (cnt == NB_KEEP)  ? self_row[x] :
                           (cnt == NB_BIRTH) ? CELL_ALIVE  : CELL_DEAD;
   end
endmodule
`default_nettype wire

// ===== rtl/life_automaton_step.sv =====
// toroidal life grid with row load, row read and one-generation step
// a step sweeps the rows in order; the shared row unit handles one row per cycle
// one command at a time: the next is taken once the result is in the output register
// reset clears the sequencer, the output valid flag and the per-row valid bits, so
//   every row reads as all dead until written; grid ram contents need no reset
`default_nettype none
module life_automaton_step #(
   parameter int GRID_WIDTH  = las_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = las_pkg::GRID_HEIGHT_DEF
) (
   input wire logic clock,
   input wire logic reset,
   las_req_if.sink  req_ch,
   las_rsp_if.source rsp_ch
);
   import las_pkg::*;

   localparam int AW = $clog2(GRID_HEIGHT);
   localparam int XW = (AW > ROW_INDEX_W) ? AW : ROW_INDEX_W;
   localparam int RW = (GRID_WIDTH > ROW_CELLS_W) ? GRID_WIDTH : ROW_CELLS_W;
   localparam logic [AW-1:0] LAST = AW'(GRID_HEIGHT - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_RDWAIT, ST_PRIME0, ST_PRIME1, ST_RUN, ST_FINISH
   } state_type;

   state_type              state_ff;
   logic [GRID_HEIGHT-1:0] valid_ff;
   logic [AW-1:0]          y_ff;
   logic [AW-1:0]          ptr_ff;
   logic [AW-1:0]          rd_addr_ff;
   logic [GRID_WIDTH-1:0]  prev_ff;
   logic [GRID_WIDTH-1:0]  self_ff;
   logic [GRID_WIDTH-1:0]  first_ff;
   logic                   hit_ff;
   logic [ROW_CELLS_W-1:0] res_data_ff;
   logic [CMD_W-1:0]       res_kind_ff;
   logic                   rsp_valid_ff;
   logic [ROW_CELLS_W-1:0] rsp_data_ff;
   logic [CMD_W-1:0]       rsp_kind_ff;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [GRID_WIDTH-1:0]  wr_data;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [GRID_WIDTH-1:0]  ram_data;
   logic [GRID_WIDTH-1:0]  rd_row;
   logic [GRID_WIDTH-1:0]  below;
   logic [GRID_WIDTH-1:0]  new_row;
   logic [RW-1:0]          rd_wide;
   logic [RW-1:0]          ld_wide;
   logic [XW-1:0]          idx_x;
   logic [AW-1:0]          idx_addr;
   logic                   in_range;
   logic                   req_xfer;
   logic [AW-1:0]          ptr_in;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;

   assign idx_x    = XW'(req_ch.row_index);
   assign idx_addr = idx_x[AW-1:0];
   assign in_range = 32'(req_ch.row_index) < GRID_HEIGHT;
   assign ld_wide  = RW'(req_ch.row_cells);

   // rows never written read as all dead
   assign rd_row  = valid_ff[rd_addr_ff] ? ram_data : '0;
   assign rd_wide = RW'(rd_row);
   assign below   = (y_ff == LAST) ? first_ff : rd_row;
   assign ptr_in  = (ptr_ff == LAST) ? '0 : ptr_ff + AW'(1);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_addr;
      wr_data = ld_wide[GRID_WIDTH-1:0];
      rd_en   = 1'b0;
      rd_addr = idx_addr;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_ch.command == CMD_LOAD && in_range) begin
               wr_en = 1'b1;
            end
            if (req_xfer && req_ch.command == CMD_READ) begin
               rd_en = 1'b1;
            end
            if (req_xfer && req_ch.command == CMD_STEP) begin
               rd_en   = 1'b1;
               rd_addr = LAST;
            end
         end
         ST_PRIME0: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         ST_PRIME1: begin
            rd_en   = 1'b1;
            rd_addr = AW'(1);
         end
         ST_RUN: begin
            rd_en   = 1'b1;
            rd_addr = ptr_ff;
            wr_en   = 1'b1;
            wr_addr = y_ff;
            wr_data = new_row;
         end
         default: begin
         end
      endcase
   end

   las_row_unit #(.GRID_WIDTH(GRID_WIDTH)) u_row (
      .above    (prev_ff),
      .self_row (self_ff),
      .below    (below),
      .next_row (new_row)
   );

   las_ram #(.WIDTH(GRID_WIDTH), .DEPTH(GRID_HEIGHT)) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_data)
   );

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_addr_ff <= rd_addr;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_ch.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  res_kind_ff <= req_ch.command;
                  res_data_ff <= '0;
                  hit_ff      <= in_range;
                  case (req_ch.command)
                     CMD_READ: state_ff <= ST_RDWAIT;
                     CMD_STEP: state_ff <= ST_PRIME0;
                     default:  state_ff <= ST_FINISH;
                  endcase
               end
            end
            ST_RDWAIT: begin
               res_data_ff <= hit_ff ? rd_wide[ROW_CELLS_W-1:0] : '0;
               state_ff    <= ST_FINISH;
            end
            ST_PRIME0: begin
               prev_ff  <= rd_row;
               state_ff <= ST_PRIME1;
            end
            ST_PRIME1: begin
               first_ff <= rd_row;
               self_ff  <= rd_row;
               y_ff     <= '0;
               ptr_ff   <= AW'(2);
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               prev_ff <= self_ff;
               self_ff <= below;
               y_ff    <= y_ff + AW'(1);
               ptr_ff  <= ptr_in;
               if (y_ff == LAST) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_data_ff <= res_data_ff;
                  rsp_kind_ff <= res_kind_ff;
                  state_ff    <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.row_data  = rsp_data_ff;
   assign rsp_ch.done_kind = rsp_kind_ff;

   a_step_enters_prime: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_ch.command == CMD_STEP) |=> (state_ff == ST_PRIME0))
      else $error("step transfer did not start the row sweep");

   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && y_ff == LAST) |=> (state_ff == ST_FINISH))
      else $error("row sweep did not end after the last row");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result appeared outside the finish step");

   a_write_marks_row: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(wr_addr)])
      else $error("written row not marked valid");

   a_write_source: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_RUN || (req_xfer && req_ch.command == CMD_LOAD)))
      else $error("grid written outside load or sweep");
endmodule
`default_nettype wire
